// File: src/cln_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the command line normalizer.
// Used by cln_decode, cln_burst and command_line_normalizer_unit; no dependencies.
package cln_pkg;

  // Line status carried on every result beat.
  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_OK       = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_INVALID  = 2'd3
  } status_e;

  // Character codes that steer the decoder.
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChQuote   = 8'h27;
  localparam logic [7:0] ChOpen    = 8'h28;
  localparam logic [7:0] ChClose   = 8'h29;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChUnder   = 8'h5F;
  localparam logic [7:0] ChAt      = 8'h40;
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChHash    = 8'h23;

  // Most result beats that one input byte can produce.
  localparam int unsigned MaxBeats = 3;

  // Group of result beats produced by one input byte.
  typedef struct packed {
    logic [1:0]            cnt;        // number of beats, 0 to 3
    logic [2:0][7:0]       chars;      // beat characters, slot 0 first
    logic                  char_valid; // beats carry characters
    status_e               status;     // status of every beat in the group
  } burst_t;

endpackage

// File: src/cln_decode.sv
`timescale 1ns / 1ps
// Combinational byte decoder: classifies one byte against the line state and
// builds its result beats and the next line state. Depends on cln_pkg.
module cln_decode #(
  parameter int unsigned MAX_NESTING = 255,
  parameter int unsigned DepthW      = 8
) (
  input  logic [7:0]        in_char_i,
  input  logic              nonempty_i,
  input  logic              last_space_i,
  input  logic              quote_open_i,
  input  logic [DepthW-1:0] depth_i,
  output cln_pkg::burst_t   burst_o,
  output logic              nonempty_o,
  output logic              last_space_o,
  output logic              quote_open_o,
  output logic [DepthW-1:0] depth_o
);

  logic is_plain;
  logic space_ok;
  logic at_max;

  // Letters, digits and the four pass-through symbols.
  assign is_plain = (in_char_i >= 8'h61 && in_char_i <= 8'h7A) ||
                    (in_char_i >= 8'h41 && in_char_i <= 8'h5A) ||
                    (in_char_i >= 8'h30 && in_char_i <= 8'h39) ||
                    in_char_i == cln_pkg::ChUnder  || in_char_i == cln_pkg::ChAt ||
                    in_char_i == cln_pkg::ChDollar || in_char_i == cln_pkg::ChHash;

  // A space is only emitted after a non-space character on this line.
  assign space_ok = nonempty_i && !last_space_i;
  assign at_max   = ({{(32-DepthW){1'b0}}, depth_i} >= 32'(MAX_NESTING));

  // Decode one byte.
  always_comb begin
    burst_o.cnt        = 2'd0;
    burst_o.chars      = '0;
    burst_o.char_valid = 1'b1;
    burst_o.status     = cln_pkg::ST_PROGRESS;
    nonempty_o         = nonempty_i;
    last_space_o       = last_space_i;
    quote_open_o       = quote_open_i;
    depth_o            = depth_i;

    if (in_char_i == cln_pkg::ChSemi) begin
      burst_o.cnt        = 2'd1;
      burst_o.char_valid = 1'b0;
      burst_o.status     = (quote_open_i || depth_i != '0) ? cln_pkg::ST_MISMATCH
                                                           : cln_pkg::ST_OK;
    end else if (in_char_i == cln_pkg::ChSpace) begin
      if (space_ok) begin
        burst_o.cnt      = 2'd1;
        burst_o.chars[0] = cln_pkg::ChSpace;
        last_space_o     = 1'b1;
      end
    end else if (in_char_i == cln_pkg::ChQuote) begin
      quote_open_o = !quote_open_i;
    end else if (in_char_i == cln_pkg::ChOpen) begin
      if (at_max) begin
        burst_o.cnt        = 2'd1;
        burst_o.char_valid = 1'b0;
        burst_o.status     = cln_pkg::ST_MISMATCH;
      end else begin
        depth_o = depth_i + DepthW'(1);
      end
    end else if (in_char_i == cln_pkg::ChClose) begin
      if (depth_i == '0) begin
        burst_o.cnt        = 2'd1;
        burst_o.char_valid = 1'b0;
        burst_o.status     = cln_pkg::ST_MISMATCH;
      end else begin
        depth_o = depth_i - DepthW'(1);
      end
    end else if (in_char_i == cln_pkg::ChComma || in_char_i == cln_pkg::ChColon) begin
      // Separator gets a space on each side; the leading one may be merged.
      if (space_ok) begin
        burst_o.cnt      = 2'd3;
        burst_o.chars[0] = cln_pkg::ChSpace;
        burst_o.chars[1] = in_char_i;
        burst_o.chars[2] = cln_pkg::ChSpace;
      end else begin
        burst_o.cnt      = 2'd2;
        burst_o.chars[0] = in_char_i;
        burst_o.chars[1] = cln_pkg::ChSpace;
      end
      nonempty_o   = 1'b1;
      last_space_o = 1'b1;
    end else if (in_char_i == cln_pkg::ChNewline) begin
      burst_o.cnt = 2'd0;
    end else if (is_plain) begin
      burst_o.cnt      = 2'd1;
      burst_o.chars[0] = in_char_i;
      nonempty_o       = 1'b1;
      last_space_o     = 1'b0;
    end else begin
      burst_o.cnt        = 2'd1;
      burst_o.char_valid = 1'b0;
      burst_o.status     = cln_pkg::ST_INVALID;
    end

    // Any terminating status clears the line state.
    if (!burst_o.char_valid) begin
      nonempty_o   = 1'b0;
      last_space_o = 1'b0;
      quote_open_o = 1'b0;
      depth_o      = '0;
    end
  end

endmodule

// File: src/cln_burst.sv
`timescale 1ns / 1ps
// Result register: holds the beats of one decoded byte and shifts them out
// one per cycle while the output is not stalled. Depends on cln_pkg.
module cln_burst (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  cln_pkg::burst_t burst_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_char_o,
  output logic            char_valid_o,
  output logic            last_o,
  output logic [1:0]      status_o
);

  logic [1:0]       cnt_q, cnt_d;
  logic [2:0][7:0]  chars_q, chars_d;
  logic             char_valid_q;
  cln_pkg::status_e status_q;
  logic             pop;

  assign pop         = out_valid_o && !out_stall_i;
  // A new byte may load when the register is empty or its final beat leaves now.
  assign free_o      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
  assign out_valid_o = (cnt_q != 2'd0);

  assign out_char_o   = chars_q[0];
  assign char_valid_o = char_valid_q;
  assign last_o       = (cnt_q == 2'd1);
  assign status_o     = status_q;

  // Load a new group or shift the taken beat out.
  always_comb begin
    cnt_d   = cnt_q;
    chars_d = chars_q;
    if (load_i) begin
      cnt_d   = burst_i.cnt;
      chars_d = burst_i.chars;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      chars_d = {8'h00, chars_q[2], chars_q[1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
    if (load_i) begin
      char_valid_q <= burst_i.char_valid;
      status_q     <= burst_i.status;
    end
  end

endmodule

// File: src/command_line_normalizer_unit.sv
`timescale 1ns / 1ps
// The first result beat of a byte appears in the cycle after it is accepted.
// The result register holds the beats of one byte, one to three (comma or colon
// with spacing), until they are taken; bytes with no beat leave it free.
// The result register shifts out one beat per cycle while the output is not stalled.
// Reset (rst_ni low, asynchronous) clears the line state and empties the register.
module command_line_normalizer_unit #(
  parameter int unsigned MAX_NESTING = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       last_o,
  output logic [1:0] status_o
);

  localparam int unsigned DepthW = (MAX_NESTING < 2) ? 1 : $clog2(MAX_NESTING + 1);

  logic              nonempty_q, nonempty_d;
  logic              last_space_q, last_space_d;
  logic              quote_open_q, quote_open_d;
  logic [DepthW-1:0] depth_q, depth_d;
  cln_pkg::burst_t   burst;
  logic              free;
  logic              accept;

  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  // Byte decode against the current line state.
  cln_decode #(
    .MAX_NESTING (MAX_NESTING),
    .DepthW      (DepthW)
  ) u_decode (
    .in_char_i    (in_char_i),
    .nonempty_i   (nonempty_q),
    .last_space_i (last_space_q),
    .quote_open_i (quote_open_q),
    .depth_i      (depth_q),
    .burst_o      (burst),
    .nonempty_o   (nonempty_d),
    .last_space_o (last_space_d),
    .quote_open_o (quote_open_d),
    .depth_o      (depth_d)
  );

  // Line state advances on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q   <= 1'b0;
      last_space_q <= 1'b0;
      quote_open_q <= 1'b0;
      depth_q      <= '0;
    end else if (accept) begin
      nonempty_q   <= nonempty_d;
      last_space_q <= last_space_d;
      quote_open_q <= quote_open_d;
      depth_q      <= depth_d;
    end
  end

  // Result register and beat sequencing.
  cln_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .burst_i      (burst),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .char_valid_o (char_valid_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

  // A semicolon always yields a single status beat next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_char_i == cln_pkg::ChSemi |=> out_valid_o && !char_valid_o && last_o)
    else $error("semicolon did not produce a single status beat");

  // Character beats always report the line as in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_valid_o |-> status_o == cln_pkg::ST_PROGRESS)
    else $error("character beat carries a terminating status");

  // Status beats stand alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !char_valid_o |-> last_o)
    else $error("status beat not marked last");

  // Input only stalls while results are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty result register");

endmodule

// File: tb/tb_command_line_normalizer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for command_line_normalizer_unit: directed bytes, a short nesting run,
// a receiver hold-off and random command lines, with every result beat checked against a line predictor.
// Depends on cln_pkg and the command_line_normalizer_unit RTL.
module tb_command_line_normalizer_unit;

  localparam int unsigned MaxNest    = 255;
  localparam int unsigned NestRun    = 6;
  localparam int unsigned RandItems  = 110;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned IdlePct    = 12;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned WatchLimit = 3000;

  // One expected result beat.
  typedef struct {
    logic [7:0]       ch;
    logic             cv;
    logic             is_last;
    cln_pkg::status_e st;
  } line_beat_t;

  // Predicts the normalized line and checks result beats in order.
  class normalizer_scoreboard;
    line_beat_t  expected_beats[$];
    bit          line_nonempty;
    bit          last_was_space;
    bit          quote_open;
    int unsigned paren_depth;
    int          errors;

    function new();
      clear_line();
      errors = 0;
    endfunction

    function void clear_line();
      line_nonempty  = 1'b0;
      last_was_space = 1'b0;
      quote_open     = 1'b0;
      paren_depth    = 0;
    endfunction

    function void emit_char(logic [7:0] c);
      line_beat_t b;
      b.ch = c;
      b.cv = 1'b1;
      b.is_last = 1'b0;
      b.st = cln_pkg::ST_PROGRESS;
      expected_beats.push_back(b);
      line_nonempty  = 1'b1;
      last_was_space = (c == cln_pkg::ChSpace);
    endfunction

    // A terminating status is a single status-only beat and resets the line.
    function void emit_status(cln_pkg::status_e st);
      line_beat_t b;
      b.ch = 8'h00;
      b.cv = 1'b0;
      b.is_last = 1'b1;
      b.st = st;
      expected_beats.push_back(b);
      clear_line();
    endfunction

    function bit is_plain(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
             c == cln_pkg::ChUnder || c == cln_pkg::ChAt ||
             c == cln_pkg::ChDollar || c == cln_pkg::ChHash;
    endfunction

    // Works out the beats caused by one accepted input byte.
    function void normalize_byte(logic [7:0] c);
      int unsigned before_cnt;
      before_cnt = expected_beats.size();
      if (c == cln_pkg::ChSemi) begin
        emit_status((quote_open || paren_depth != 0) ? cln_pkg::ST_MISMATCH : cln_pkg::ST_OK);
        return;
      end
      if (c == cln_pkg::ChSpace) begin
        if (line_nonempty && !last_was_space) emit_char(cln_pkg::ChSpace);
      end else if (c == cln_pkg::ChQuote) begin
        quote_open = !quote_open;
      end else if (c == cln_pkg::ChOpen) begin
        if (paren_depth >= MaxNest) begin
          emit_status(cln_pkg::ST_MISMATCH);
          return;
        end
        paren_depth++;
      end else if (c == cln_pkg::ChClose) begin
        if (paren_depth == 0) begin
          emit_status(cln_pkg::ST_MISMATCH);
          return;
        end
        paren_depth--;
      end else if (c == cln_pkg::ChComma || c == cln_pkg::ChColon) begin
        if (line_nonempty && !last_was_space) emit_char(cln_pkg::ChSpace);
        emit_char(c);
        emit_char(cln_pkg::ChSpace);
      end else if (c == cln_pkg::ChNewline) begin
        // Newlines are dropped.
      end else if (is_plain(c)) begin
        emit_char(c);
      end else begin
        emit_status(cln_pkg::ST_INVALID);
        return;
      end
      if (expected_beats.size() > before_cnt)
        expected_beats[expected_beats.size() - 1].is_last = 1'b1;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void check_beat(logic [7:0] ch, logic cv, logic lst, logic [1:0] st);
      line_beat_t b;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: out_char=%h char_valid=%b last=%b status=%0d",
               ch, cv, lst, st);
        errors++;
        return;
      end
      b = expected_beats.pop_front();
      if (ch !== b.ch) begin
        $error("out_char: expected %h, actual %h", b.ch, ch);
        errors++;
      end
      if (cv !== b.cv) begin
        $error("char_valid: expected %b, actual %b", b.cv, cv);
        errors++;
      end
      if (lst !== b.is_last) begin
        $error("last: expected %b, actual %b", b.is_last, lst);
        errors++;
      end
      if (st !== b.st) begin
        $error("status: expected %0d, actual %0d", b.st, st);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_char_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_char_o;
  logic       char_valid_o;
  logic       last_o;
  logic [1:0] status_o;

  normalizer_scoreboard sb;
  bit          quiet;
  bit          hold_req;
  int unsigned sent_cnt;
  int unsigned stuck_cycles;

  command_line_normalizer_unit #(
    .MAX_NESTING(MaxNest)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_char_i   (in_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .char_valid_o(char_valid_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Receiver: random stalls, or one long hold-off when requested.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < IdlePct);
      end
    end
  end

  // Every accepted result beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_beat(out_char_o, char_valid_o, last_o, status_o);
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WatchLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offers one byte, with an occasional random gap, and waits for its acceptance.
  task automatic send_byte(input logic [7:0] c);
    if (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 50);
    end
    in_valid_i <= 1'b1;
    in_char_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.normalize_byte(c);
    sent_cnt++;
  endtask

  // Stops offering until every expected beat has arrived.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] plain_char();
    int unsigned r;
    r = $urandom_range(0, 65);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    case (r)
      62:      return cln_pkg::ChUnder;
      63:      return cln_pkg::ChAt;
      64:      return cln_pkg::ChDollar;
      default: return cln_pkg::ChHash;
    endcase
  endfunction

  task automatic send_word();
    int unsigned n;
    n = $urandom_range(1, 4);
    repeat (n) send_byte(plain_char());
  endtask

  // One random command line; a broken line may carry stray or invalid bytes and may lack its semicolon.
  task automatic send_line(input bit broken);
    int unsigned ntok;
    int unsigned depth;
    ntok = $urandom_range(1, 7);
    for (int i = 0; i < ntok; i++) begin
      case ($urandom_range(0, 7))
        0, 1, 2: send_word();
        3:       repeat ($urandom_range(1, 3)) send_byte(cln_pkg::ChSpace);
        4:       send_byte($urandom_range(0, 1) ? cln_pkg::ChComma : cln_pkg::ChColon);
        5: begin
          send_byte(cln_pkg::ChQuote);
          send_word();
          send_byte(cln_pkg::ChSpace);
          send_word();
          send_byte(cln_pkg::ChQuote);
        end
        6: begin
          depth = $urandom_range(1, 3);
          repeat (depth) send_byte(cln_pkg::ChOpen);
          send_word();
          repeat (depth) send_byte(cln_pkg::ChClose);
        end
        default: send_byte(cln_pkg::ChNewline);
      endcase
      if (broken && $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0:       send_byte(8'($urandom_range(0, 255)));
          1:       send_byte(cln_pkg::ChClose);
          2:       send_byte(cln_pkg::ChQuote);
          default: send_byte(cln_pkg::ChOpen);
        endcase
      end
    end
    if (!broken || $urandom_range(0, 3) != 0) send_byte(cln_pkg::ChSemi);
  endtask

  // Main sequence.
  initial begin
    logic [7:0] directed[$];
    int unsigned rand_start;
    sb         = new();
    quiet      = 1'b0;
    hold_req   = 1'b0;
    sent_cnt   = 0;
    stuck_cycles = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_char_i  = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed bytes: leading and repeated spaces, separators, drops, all terminations.
    directed = '{cln_pkg::ChSpace, cln_pkg::ChComma, cln_pkg::ChSpace, "a",
                 cln_pkg::ChSpace, cln_pkg::ChSpace, cln_pkg::ChColon, "Z",
                 cln_pkg::ChComma, cln_pkg::ChNewline, "9", cln_pkg::ChUnder,
                 cln_pkg::ChAt, cln_pkg::ChDollar, cln_pkg::ChHash, cln_pkg::ChQuote,
                 cln_pkg::ChSemi, cln_pkg::ChClose, cln_pkg::ChOpen, cln_pkg::ChSemi,
                 "x", cln_pkg::ChSemi, 8'h00, 8'hFF, 8'h80, 8'h21, cln_pkg::ChSemi};
    foreach (directed[i]) send_byte(directed[i]);

    // Nesting run: open a few levels, close them all and end the line cleanly.
    repeat (NestRun) send_byte(cln_pkg::ChOpen);
    repeat (NestRun) send_byte(cln_pkg::ChClose);
    send_byte(cln_pkg::ChSemi);
    drain_results();

    // Long receiver hold-off while separators keep arriving.
    hold_req = 1'b1;
    send_byte("q");
    repeat (12) send_byte($urandom_range(0, 1) ? cln_pkg::ChComma : cln_pkg::ChColon);
    send_byte(cln_pkg::ChSemi);

    // Random lines, mostly well formed, with a quiet stretch and a drain midway.
    rand_start = sent_cnt;
    while (sent_cnt - rand_start < RandItems) begin
      if (sent_cnt - rand_start > 20 && sent_cnt - rand_start < 50) quiet = 1'b1;
      else quiet = 1'b0;
      if ($urandom_range(0, 9) < 8) send_line(1'b0);
      else if ($urandom_range(0, 1)) send_line(1'b1);
      else send_byte(8'($urandom_range(0, 255)));
      if (sent_cnt - rand_start > 70 && sent_cnt - rand_start < 80) drain_results();
    end
    quiet = 1'b0;

    // Wait for the remaining beats and a short tail for strays.
    drain_results();
    if (sb.pending() != 0) begin
      $error("%0d expected beats never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
